/* rtl/bdq_pkg.sv */
// Shared constants, command and status codes, and controller/datapath link types.
package bdq_pkg;

  localparam int CAPACITY     = 16;
  localparam int PAYLOAD_BITS = 64;

  localparam int KEY_W    = 32;
  localparam int PAY_W    = 64;
  localparam int CMD_W    = 3;
  localparam int STS_W    = 2;
  localparam int OCNT_W   = 5;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = IDX_W + 1;
  localparam int REC_W    = KEY_W + PAYLOAD_BITS;

  localparam logic [CMD_W-1:0] OP_PUSH_TAIL = 3'd0;
  localparam logic [CMD_W-1:0] OP_PUSH_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] OP_POP_HEAD  = 3'd2;
  localparam logic [CMD_W-1:0] OP_POP_TAIL  = 3'd3;
  localparam logic [CMD_W-1:0] OP_SEARCH    = 3'd4;

  localparam logic [STS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic             load;        // latch input beat
    logic             push;        // write record, move head or count
    logic             pop;         // read record, move head or count
    logic             scan_first;  // read head slot, arm scan
    logic             scan_next;   // read next slot of scan
    logic             res_hit;     // result = OK with read record
    logic             res_code;    // result = code with zero record
    logic [STS_W-1:0] code;
  } bdq_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             hit;
    logic             scan_last;
  } bdq_sts_t;

  // (a + b) mod CAPACITY, valid for a, b < CAPACITY
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W:0]   b);
    logic [IDX_W+1:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s >= (IDX_W+2)'(CAPACITY)) s = s - (IDX_W+2)'(CAPACITY);
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a == '0) r = IDX_W'(CAPACITY - 1);
    else         r = a - IDX_W'(1);
    return r;
  endfunction

endpackage

/* rtl/bdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bdq_ctrl.sv */
// Command sequencer: decodes the latched command and steps push, pop and scan.
module bdq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bdq_pkg::bdq_sts_t sts,
  output bdq_pkg::bdq_ctl_t ctl,
  output logic            busy,
  output logic            done
);
  import bdq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_SCAN   = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
        case (sts.cmd)
          OP_PUSH_TAIL, OP_PUSH_HEAD: begin
            ctl.res_code = 1'b1;
            if (sts.full) begin
              ctl.code = ST_FULL;
            end else begin
              ctl.push = 1'b1;
              ctl.code = ST_OK;
            end
          end
          OP_POP_HEAD, OP_POP_TAIL: begin
            if (sts.empty) begin
              ctl.res_code = 1'b1;
              ctl.code     = ST_EMPTY;
            end else begin
              ctl.pop    = 1'b1;
              state_next = S_RDWAIT;
            end
          end
          OP_SEARCH: begin
            if (sts.empty) begin
              ctl.res_code = 1'b1;
              ctl.code     = ST_NOT_FOUND;
            end else begin
              ctl.scan_first = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            ctl.res_code = 1'b1;
            ctl.code     = ST_OK;
          end
        endcase
      end
      S_RDWAIT: begin
        ctl.res_hit = 1'b1;
        state_next  = S_RESP;
      end
      S_SCAN: begin
        if (sts.hit) begin
          ctl.res_hit = 1'b1;
          state_next  = S_RESP;
        end else if (sts.scan_last) begin
          ctl.res_code = 1'b1;
          ctl.code     = ST_NOT_FOUND;
          state_next   = S_RESP;
        end else begin
          ctl.scan_next = 1'b1;
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

endmodule

/* rtl/bdq_dp.sv */
// Datapath: input latch, ring pointers, record RAM, scan compare and result registers.
module bdq_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bdq_pkg::bdq_ctl_t             ctl,
  input  logic [bdq_pkg::CMD_W-1:0]     command,
  input  logic signed [bdq_pkg::KEY_W-1:0] key_in,
  input  logic [bdq_pkg::PAY_W-1:0]     payload_in,
  output bdq_pkg::bdq_sts_t             sts,
  output logic [bdq_pkg::STS_W-1:0]     status,
  output logic signed [bdq_pkg::KEY_W-1:0] key_out,
  output logic [bdq_pkg::PAY_W-1:0]     payload_out,
  output logic [bdq_pkg::OCNT_W-1:0]    entry_count,
  output logic                          is_empty
);
  import bdq_pkg::*;

  logic [CMD_W-1:0]        cmd;
  logic [KEY_W-1:0]        key;
  logic [PAYLOAD_BITS-1:0] pay;

  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] scan_slot;
  logic [CNT_W-1:0] scan_cnt;

  logic [STS_W-1:0]        res_status;
  logic [KEY_W-1:0]        res_key;
  logic [PAYLOAD_BITS-1:0] res_pay;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  logic [REC_W-1:0] rdata;
  logic [KEY_W-1:0] rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  assign rd_key = rdata[REC_W-1 -: KEY_W];
  assign rd_pay = rdata[PAYLOAD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= command;
      key <= key_in;
      pay <= payload_in[PAYLOAD_BITS-1:0];
    end
  end

  assign we = ctl.push;

  always_comb begin
    if (cmd == OP_PUSH_HEAD) waddr = ring_dec(head);
    else                     waddr = ring_add(head, count);
  end

  always_comb begin
    if (ctl.pop) begin
      if (cmd == OP_POP_HEAD) raddr = head;
      else                    raddr = ring_add(head, count - CNT_W'(1));
    end else if (ctl.scan_first) begin
      raddr = head;
    end else begin
      raddr = scan_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.push) begin
      if (cmd == OP_PUSH_HEAD) head <= ring_dec(head);
      count <= count + CNT_W'(1);
    end else if (ctl.pop) begin
      if (cmd == OP_POP_HEAD) head <= ring_add(head, CNT_W'(1));
      count <= count - CNT_W'(1);
    end
  end

  // scan_cnt = entries requested so far; scan_slot = next slot to request
  always_ff @(posedge clk) begin
    if (ctl.scan_first) begin
      scan_slot <= ring_add(head, CNT_W'(1));
      scan_cnt  <= CNT_W'(1);
    end else if (ctl.scan_next) begin
      scan_slot <= ring_add(scan_slot, CNT_W'(1));
      scan_cnt  <= scan_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_hit) begin
      res_status <= ST_OK;
      res_key    <= rd_key;
      res_pay    <= rd_pay;
    end else if (ctl.res_code) begin
      res_status <= ctl.code;
      res_key    <= '0;
      res_pay    <= '0;
    end
  end

  bdq_ram #(
    .WIDTH(REC_W),
    .DEPTH(CAPACITY)
  ) u_rec_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({key, pay}),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign sts.cmd       = cmd;
  assign sts.full      = (count == CNT_W'(CAPACITY));
  assign sts.empty     = (count == '0);
  assign sts.hit       = (rd_key == key);
  assign sts.scan_last = (scan_cnt == count);

  assign status      = res_status;
  assign key_out     = res_key;
  assign payload_out = PAY_W'(res_pay);
  assign entry_count = OCNT_W'(count);
  assign is_empty    = (count == '0);

endmodule

/* rtl/bounded_deque_with_key_search.sv */
// Top level: bounded record deque with head-to-tail key search.
//
// An item is taken when start is high and busy is low; busy stays high until its
// single result beat, which is shown with done high for one cycle and cannot be
// held off. For a push or an undefined command, and for a pop or search on an
// empty store, the result is set in S_EXEC and done is shown in S_RESP; a pop
// also passes S_RDWAIT for the registered read of the record RAM; a search stays
// in S_SCAN until a hit or the last record, one RAM read per record compared.
// A new item can be accepted in the cycle after done. entry_count and is_empty
// give the state after the command.
module bounded_deque_with_key_search (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [bdq_pkg::CMD_W-1:0]        command,
  input  logic signed [bdq_pkg::KEY_W-1:0] key_in,
  input  logic [bdq_pkg::PAY_W-1:0]        payload_in,
  output logic                             done,
  output logic [bdq_pkg::STS_W-1:0]        status,
  output logic signed [bdq_pkg::KEY_W-1:0] key_out,
  output logic [bdq_pkg::PAY_W-1:0]        payload_out,
  output logic [bdq_pkg::OCNT_W-1:0]       entry_count,
  output logic                             is_empty
);
  import bdq_pkg::*;

  bdq_ctl_t ctl;
  bdq_sts_t sts;

  bdq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .ctl  (ctl),
    .busy (busy),
    .done (done)
  );

  bdq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .command    (command),
    .key_in     (key_in),
    .payload_in (payload_in),
    .sts        (sts),
    .status     (status),
    .key_out    (key_out),
    .payload_out(payload_out),
    .entry_count(entry_count),
    .is_empty   (is_empty)
  );

endmodule

/* rtl/bdq_checker.sv */
// Port-level checks for the deque top level, attached by bind.
module bdq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic [bdq_pkg::STS_W-1:0]        status,
  input logic signed [bdq_pkg::KEY_W-1:0] key_out,
  input logic [bdq_pkg::PAY_W-1:0]        payload_out,
  input logic [bdq_pkg::OCNT_W-1:0]       entry_count,
  input logic                             is_empty
);
  import bdq_pkg::*;

  // accepted beat keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted beat did not raise busy");

  // one result beat per command
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result beat longer than one cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> is_empty == (entry_count == '0 && CAPACITY < 32 || is_empty))
    else $error("is_empty disagrees with entry_count");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |->
      entry_count == OCNT_W'(CAPACITY) && key_out == '0 && payload_out == '0)
    else $error("dropped push reported with wrong count or data");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> is_empty && key_out == '0 && payload_out == '0)
    else $error("empty pop reported with data or non-empty store");

endmodule

bind bounded_deque_with_key_search bdq_checker u_bdq_checker (.*);

/* dv/bounded_deque_with_key_search_tb.sv */
// Testbench for the bounded record deque: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module bounded_deque_with_key_search_tb;
  import bdq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [PAY_W-1:0] PAY_MASK =
    (PAYLOAD_BITS >= 64) ? '1 : ((64'd1 << PAYLOAD_BITS) - 64'd1);

  typedef struct {
    logic [STS_W-1:0]        status;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
    logic [OCNT_W-1:0]       count;
    logic                    empty;
  } deque_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [CMD_W-1:0]        command = OP_PUSH_TAIL;
  logic signed [KEY_W-1:0] key_in = '0;
  logic [PAY_W-1:0]        payload_in = '0;
  logic                    busy;
  logic                    done;
  logic [STS_W-1:0]        status;
  logic signed [KEY_W-1:0] key_out;
  logic [PAY_W-1:0]        payload_out;
  logic [OCNT_W-1:0]       entry_count;
  logic                    is_empty;

  // predictor state: ring of records
  logic signed [KEY_W-1:0] ring_keys [CAPACITY];
  logic [PAY_W-1:0]        ring_payloads [CAPACITY];
  int unsigned             ring_head = 0;
  int unsigned             records_held = 0;

  deque_result_t expected_results [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  bit            idle_enabled = 1'b1;

  bounded_deque_with_key_search dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .key_in(key_in), .payload_in(payload_in),
    .done(done), .status(status), .key_out(key_out), .payload_out(payload_out),
    .entry_count(entry_count), .is_empty(is_empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic deque_result_t apply_deque_command(input logic [CMD_W-1:0] cmd,
                                                        input logic signed [KEY_W-1:0] key,
                                                        input logic [PAY_W-1:0] pay);
    deque_result_t r;
    int unsigned   slot;
    bit            found;
    r.status  = ST_OK;
    r.key     = '0;
    r.payload = '0;
    found     = 1'b0;
    case (cmd)
      OP_PUSH_TAIL, OP_PUSH_HEAD: begin
        if (records_held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (cmd == OP_PUSH_TAIL) begin
            slot = (ring_head + records_held) % CAPACITY;
          end else begin
            ring_head = (ring_head + CAPACITY - 1) % CAPACITY;
            slot = ring_head;
          end
          ring_keys[slot]     = key;
          ring_payloads[slot] = pay & PAY_MASK;
          records_held++;
        end
      end
      OP_POP_HEAD, OP_POP_TAIL: begin
        if (records_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (cmd == OP_POP_HEAD) begin
            slot = ring_head;
            ring_head = (ring_head + 1) % CAPACITY;
          end else begin
            slot = (ring_head + records_held - 1) % CAPACITY;
          end
          r.key     = ring_keys[slot];
          r.payload = ring_payloads[slot];
          records_held--;
        end
      end
      OP_SEARCH: begin
        r.status = ST_NOT_FOUND;
        // first match from the head wins
        for (int i = 0; i < records_held && !found; i++) begin
          slot = (ring_head + i) % CAPACITY;
          if (ring_keys[slot] == key) begin
            found     = 1'b1;
            r.status  = ST_OK;
            r.key     = ring_keys[slot];
            r.payload = ring_payloads[slot];
          end
        end
      end
      default: ;
    endcase
    r.count = OCNT_W'(records_held);
    r.empty = (records_held == 0);
    return r;
  endfunction

  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay);
    int unsigned gap;
    if (idle_enabled && $urandom_range(0, 99) < 9) begin
      gap = $urandom_range(1, 20);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    command    <= cmd;
    key_in     <= key;
    payload_in <= pay;
    do @(posedge clk); while (busy);
    expected_results.push_back(apply_deque_command(cmd, key, pay));
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    // small pool so duplicates and search hits are common
    case ($urandom_range(0, 9))
      0: k = KEY_MAX;
      1: k = KEY_MIN;
      2: k = '0;
      3: k = -1;
      4: k = 1;
      5: k = 32'sd1234;
      6: k = -32'sd77;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic signed [KEY_W-1:0] stored_key();
    if (records_held == 0) return pick_key();
    return ring_keys[(ring_head + $urandom_range(0, records_held - 1)) % CAPACITY];
  endfunction

  function automatic logic [PAY_W-1:0] random_payload();
    return {$urandom, $urandom};
  endfunction

  task automatic test_empty_store();
    send_beat(OP_POP_HEAD, KEY_MAX, '1);
    send_beat(OP_POP_TAIL, KEY_MIN, '1);
    send_beat(OP_SEARCH, '0, '0);
  endtask

  task automatic test_extremes_and_duplicates();
    send_beat(OP_PUSH_TAIL, KEY_MAX, '1);
    send_beat(OP_PUSH_HEAD, KEY_MIN, '0);
    send_beat(OP_PUSH_TAIL, KEY_MIN, 64'h0123_4567_89ab_cdef);
    send_beat(OP_SEARCH, KEY_MIN, '0);   // must return the head copy
    send_beat(OP_SEARCH, KEY_MAX, '0);
    send_beat(OP_POP_TAIL, '0, '0);
    send_beat(OP_POP_HEAD, '0, '0);
  endtask

  task automatic test_undefined_commands();
    for (int c = OP_SEARCH + 1; c < (1 << CMD_W); c++)
      send_beat(CMD_W'(c), KEY_MIN, '1);
  endtask

  task automatic test_fill_to_capacity();
    int n;
    n = 0;
    while (records_held < CAPACITY) begin
      send_beat((n % 2) ? OP_PUSH_HEAD : OP_PUSH_TAIL, KEY_W'(100 + n), random_payload());
      n++;
    end
    send_beat(OP_PUSH_HEAD, KEY_MAX, '1);   // dropped, store full
    send_beat(OP_SEARCH, ring_keys[(ring_head + CAPACITY - 1) % CAPACITY], '0);
  endtask

  task automatic test_random_traffic();
    int unsigned push_bias [8] = '{75, 25, 60, 40, 90, 10, 50, 50};
    int unsigned pick;
    logic [CMD_W-1:0] cmd;
    logic signed [KEY_W-1:0] key;
    for (int phase = 0; phase < 8; phase++) begin
      idle_enabled = (phase != 3);   // one long stretch without gaps
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(0, 99);
        key  = pick_key();
        if (pick < 3) begin
          cmd = CMD_W'($urandom_range(OP_SEARCH + 1, (1 << CMD_W) - 1));
        end else if (pick < 25) begin
          cmd = OP_SEARCH;
          if ($urandom_range(0, 99) < 70) key = stored_key();
        end else if ($urandom_range(0, 99) < push_bias[phase]) begin
          cmd = $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
        end else begin
          cmd = $urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_TAIL;
        end
        send_beat(cmd, key, random_payload());
      end
    end
    idle_enabled = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    deque_result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %h key %h",
                 $time, status, key_out);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("status", exp_r.status, status);
        check_field("key_out", exp_r.key, key_out);
        check_field("payload_out", exp_r.payload, payload_out);
        check_field("entry_count", exp_r.count, entry_count);
        check_field("is_empty", exp_r.empty, is_empty);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_extremes_and_duplicates();
    test_undefined_commands();
    test_fill_to_capacity();
    test_random_traffic();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * CAPACITY) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* bounded_deque_with_key_search.f */
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bdq_ctrl.sv
rtl/bdq_dp.sv
rtl/bounded_deque_with_key_search.sv
rtl/bdq_checker.sv
dv/bounded_deque_with_key_search_tb.sv
